// File: rtl/core/srq_pkg.sv
// Shared types and codes for the sorted ready queue.
// Depends on nothing; only sorted_ready_queue imports it.
package srq_pkg;

  localparam int CAPACITY_DEFAULT  = 32;
  localparam int KEY_WIDTH_DEFAULT = 16;

  localparam logic [2:0] ACT_INS_SORT = 3'd0;
  localparam logic [2:0] ACT_INS_AT   = 3'd1;
  localparam logic [2:0] ACT_POP      = 3'd2;
  localparam logic [2:0] ACT_REMOVE   = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;
  localparam logic [2:0] ACT_FIND_ID  = 3'd5;
  localparam logic [2:0] ACT_FIND_WIN = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] priority_val;
    logic [15:0] duration;
    logic [15:0] ticket_a;
    logic [15:0] ticket_b;
    logic        busy;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] entry_id;
    logic [15:0] priority_req;
    logic [15:0] duration;
    logic [15:0] ticket_a;
    logic [15:0] ticket_b;
    logic        busy_req;
    logic [7:0]  position;
    logic [15:0] winning_ticket;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic [15:0] out_id;
    logic [15:0] out_priority;
    logic [15:0] out_duration;
    logic [15:0] out_ticket_a;
    logic [15:0] out_ticket_b;
    logic        out_busy;
    logic [8:0]  occupancy;
  } rsp_t;

endpackage

// File: rtl/core/srq_chan.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Independent of the package; the payload type is given at instantiation.
interface srq_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/srq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module srq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: rtl/core/sorted_ready_queue.sv
// Sorted ready queue: top level with its sequencer and the entry memory.
// Depends on srq_pkg, srq_chan and srq_ram.

// The queue keeps up to CAPACITY task entries in one RAM with a registered
// read, and one sequencer walks that RAM a single port access at a time.
// Each read presents the address, then takes the registered data; each moved
// entry costs one read and one write. A read fetches the entry at its index;
// a pop reads the head, then moves every later entry down by one; an insert
// at index i moves the entries from the tail back to i up by one and writes
// the new entry at i; a remove at i moves the later entries down by one; a
// find reads from the head until an entry matches or none is left; a sorted
// insert scans for its place, then inserts there. Errors and the unknown
// action go straight to the result. A new transaction is taken only when the
// previous one is finished; the result sits in an output register, so the
// next request can be taken while it waits. A result that is still waiting
// holds the following one back at its end until the response side takes it.
module sorted_ready_queue #(
  parameter int CAPACITY  = srq_pkg::CAPACITY_DEFAULT,
  parameter int KEY_WIDTH = srq_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  srq_chan.sink   req,
  srq_chan.source rsp
);
  import srq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KB = (KEY_WIDTH < 16) ? KEY_WIDTH : 16;
  localparam int EW = $bits(entry_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CHK = 4'd2;
  localparam logic [3:0] S_SH_RD  = 4'd3;
  localparam logic [3:0] S_SH_WR  = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_RD_CAP = 4'd6;
  localparam logic [3:0] S_DR_RD  = 4'd7;
  localparam logic [3:0] S_DR_WR  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]    state;
  logic          sort_dur;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [AW-1:0] idx;
  req_t          op;
  logic [1:0]    res_status;
  entry_t        res_entry;
  logic          out_valid;
  rsp_t          out_data;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_raw;
  entry_t        rd_entry;
  entry_t        new_entry;
  logic [KB-1:0] rd_key;
  logic [KB-1:0] new_key;
  logic          hit;
  logic [CW-1:0] ptr_inc;
  logic          last;

  assign rd_entry = entry_t'(rd_raw);

  always_comb begin
    new_entry.id           = op.entry_id;
    new_entry.priority_val = op.priority_req;
    new_entry.duration     = op.duration;
    new_entry.ticket_a     = op.ticket_a;
    new_entry.ticket_b     = op.ticket_b;
    new_entry.busy         = op.busy_req;
  end

  assign rd_key  = sort_dur ? rd_entry.duration[KB-1:0] : rd_entry.priority_val[KB-1:0];
  assign new_key = sort_dur ? op.duration[KB-1:0] : op.priority_req[KB-1:0];
  assign ptr_inc = ptr + CW'(1);
  assign last    = (ptr_inc >= count);

  always_comb begin
    if (op.action == ACT_FIND_ID) begin
      hit = (rd_entry.id == op.entry_id);
    end else begin
      hit = ((rd_entry.ticket_a == op.winning_ticket) ||
             (rd_entry.ticket_b == op.winning_ticket)) && !rd_entry.busy;
    end
  end

  // Memory port control follows the sequencer state directly.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rd_entry;
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    case (state)
      S_SC_RD: begin
        rd_en = 1'b1;
      end
      S_SH_RD: begin
        if (ptr == CW'(idx)) begin
          wr_en   = 1'b1;
          wr_addr = idx;
          wr_data = new_entry;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr - CW'(1));
        end
      end
      S_SH_WR: begin
        wr_en = 1'b1;
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      S_DR_RD: begin
        rd_en   = !last;
        rd_addr = AW'(ptr_inc);
      end
      S_DR_WR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  srq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (EW'(wr_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_dur <= 1'b0;
    end else if (cfg_we) begin
      sort_dur <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.data;
            res_status <= ST_OK;
            res_entry  <= '0;
            idx        <= '0;
            ptr        <= '0;
            state      <= S_DONE;
            case (req.data.action)
              ACT_INS_SORT, ACT_INS_AT: begin
                if (count == CW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                end else if (req.data.action == ACT_INS_AT) begin
                  ptr   <= count;
                  state <= S_SH_RD;
                  if (9'(req.data.position) < 9'(count)) begin
                    idx <= AW'(req.data.position);
                  end else begin
                    idx <= AW'(count);
                  end
                end else if (count == '0) begin
                  state <= S_SH_RD;
                end else begin
                  state <= S_SC_RD;
                end
              end
              ACT_POP: begin
                if (count == '0) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_RD;
                end
              end
              ACT_REMOVE, ACT_READ: begin
                if (9'(req.data.position) >= 9'(count)) begin
                  res_status <= ST_RANGE;
                end else begin
                  idx   <= AW'(req.data.position);
                  ptr   <= CW'(req.data.position);
                  state <= (req.data.action == ACT_READ) ? S_RD : S_DR_RD;
                end
              end
              ACT_FIND_ID, ACT_FIND_WIN: begin
                if (count == '0) begin
                  res_status <= ST_NOT_FOUND;
                end else begin
                  state <= S_SC_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SC_RD: begin
          state <= S_SC_CHK;
        end
        S_SC_CHK: begin
          if (op.action == ACT_INS_SORT) begin
            // Step past every entry whose key does not exceed the new one.
            if (rd_key <= new_key) begin
              if (last) begin
                idx   <= AW'(count);
                ptr   <= count;
                state <= S_SH_RD;
              end else begin
                ptr   <= ptr_inc;
                state <= S_SC_RD;
              end
            end else begin
              idx   <= ptr[AW-1:0];
              ptr   <= count;
              state <= S_SH_RD;
            end
          end else if (hit) begin
            res_entry <= rd_entry;
            idx       <= ptr[AW-1:0];
            state     <= S_DONE;
          end else if (last) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            ptr   <= ptr_inc;
            state <= S_SC_RD;
          end
        end
        S_SH_RD: begin
          if (ptr == CW'(idx)) begin
            count <= count + CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          ptr   <= ptr - CW'(1);
          state <= S_SH_RD;
        end
        S_RD: begin
          state <= S_RD_CAP;
        end
        S_RD_CAP: begin
          res_entry <= rd_entry;
          if (op.action == ACT_POP) begin
            ptr   <= '0;
            state <= S_DR_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DR_RD: begin
          if (last) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_DR_WR;
          end
        end
        S_DR_WR: begin
          ptr   <= ptr_inc;
          state <= S_DR_RD;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_data.status       <= res_status;
      out_data.found_index  <= (res_status == ST_OK) ? 8'(idx) : 8'd0;
      out_data.out_id       <= res_entry.id;
      out_data.out_priority <= res_entry.priority_val;
      out_data.out_duration <= res_entry.duration;
      out_data.out_ticket_a <= res_entry.ticket_a;
      out_data.out_ticket_b <= res_entry.ticket_b;
      out_data.out_busy     <= res_entry.busy;
      out_data.occupancy    <= 9'(count);
    end
  end

endmodule
